// File: sv/p1_triangle_stiffness_assembly_assert.svh
`ifndef P1_TRIANGLE_STIFFNESS_ASSEMBLY_ASSERT_SVH
`define P1_TRIANGLE_STIFFNESS_ASSEMBLY_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define P1TSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("p1tsa: same-cycle check failed");

// next-cycle implication
`define P1TSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p1tsa: next-cycle check failed");

`endif

// File: sv/p1tsa_pkg.sv
package p1tsa_pkg;

  localparam int NODE_INDEX_BITS = 16;
  localparam int COORD_BITS      = 24;
  localparam int VALUE_BITS      = 32;

  localparam int DW         = COORD_BITS + 1;   // edge difference
  localparam int PW         = 2 * DW;           // product
  localparam int SW         = PW + 1;           // sum of two products
  localparam int MW         = SW;               // magnitude
  localparam int FRAC_SHIFT = 15;               // 2^16 scale, 0.5 area factor
  localparam int QB         = VALUE_BITS + 1;   // quotient bits kept
  localparam int CW         = MW + QB + 1;      // divider remainder
  localparam int ENTRIES    = 9;
  localparam int KW         = $clog2(ENTRIES);

  localparam logic [KW-1:0] K_LAST = KW'(ENTRIES - 1);

  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  localparam logic [1:0] LANE_A = 2'd0;
  localparam logic [1:0] LANE_B = 2'd1;
  localparam logic [1:0] LANE_C = 2'd2;

  typedef logic [NODE_INDEX_BITS-1:0] node_t;
  typedef logic signed [DW-1:0]       diff_t;
  typedef logic signed [PW-1:0]       prod_t;
  typedef logic signed [SW-1:0]       sum_t;
  typedef logic [MW-1:0]              mag_t;
  typedef logic [VALUE_BITS-1:0]      value_t;

  typedef struct packed {
    logic  valid;
    node_t row;
    node_t col;
    logic  last;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    logic neg;
    logic degen;
    mag_t mag;
    mag_t den;
  } frac_t;

  typedef struct packed {
    tag_t   tag;
    value_t value;
    logic   degen;
    logic   sat;
  } res_t;

  // column-major walk: row = k mod 3
  function automatic logic [1:0] lane_row(input logic [KW-1:0] k);
    logic [1:0] l;
    unique case (k)
      4'd0, 4'd3, 4'd6: l = LANE_A;
      4'd1, 4'd4, 4'd7: l = LANE_B;
      default:          l = LANE_C;
    endcase
    return l;
  endfunction

  // col = k div 3
  function automatic logic [1:0] lane_col(input logic [KW-1:0] k);
    logic [1:0] l;
    unique case (k)
      4'd0, 4'd1, 4'd2: l = LANE_A;
      4'd3, 4'd4, 4'd5: l = LANE_B;
      default:          l = LANE_C;
    endcase
    return l;
  endfunction

endpackage

// File: sv/p1tsa_seq.sv
module p1tsa_seq (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [p1tsa_pkg::NODE_INDEX_BITS-1:0]  in_node_a,
  input  logic [p1tsa_pkg::NODE_INDEX_BITS-1:0]  in_node_b,
  input  logic [p1tsa_pkg::NODE_INDEX_BITS-1:0]  in_node_c,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_ax,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_ay,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_bx,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_by_coord,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_cx,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_cy,
  output p1tsa_pkg::frac_t                       frac
);
  import p1tsa_pkg::*;

  logic          busy_r;
  logic [KW-1:0] k_r;
  node_t         na_r, nb_r, nc_r;
  diff_t         b0_r, b1_r, b2_r, c0_r, c1_r, c2_r;

  logic [1:0] rl, cl;
  diff_t      br, bc, cr, cc;
  node_t      nr, ncol;
  tag_t       tag1_nxt, tag1_r, tag2_r;
  prod_t      pb_r, pc_r, pd1_r, pd2_r;
  sum_t       num_r, det_r;
  frac_t      frac_nxt, frac_r;

  assign in_ready = adv && (!busy_r || k_r == K_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (adv) begin
      if (busy_r && k_r != K_LAST) begin
        k_r <= k_r + 1'b1;
      end else begin
        busy_r <= in_valid;
        k_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      na_r <= in_node_a;
      nb_r <= in_node_b;
      nc_r <= in_node_c;
      b0_r <= diff_t'(in_by_coord) - diff_t'(in_cy);
      b1_r <= diff_t'(in_cy) - diff_t'(in_ay);
      b2_r <= diff_t'(in_ay) - diff_t'(in_by_coord);
      c0_r <= diff_t'(in_cx) - diff_t'(in_bx);
      c1_r <= diff_t'(in_ax) - diff_t'(in_cx);
      c2_r <= diff_t'(in_bx) - diff_t'(in_ax);
    end
  end

  assign rl = lane_row(k_r);
  assign cl = lane_col(k_r);

  always_comb begin
    unique case (rl)
      LANE_A:  begin br = b0_r; cr = c0_r; nr = na_r; end
      LANE_B:  begin br = b1_r; cr = c1_r; nr = nb_r; end
      default: begin br = b2_r; cr = c2_r; nr = nc_r; end
    endcase
    unique case (cl)
      LANE_A:  begin bc = b0_r; cc = c0_r; ncol = na_r; end
      LANE_B:  begin bc = b1_r; cc = c1_r; ncol = nb_r; end
      default: begin bc = b2_r; cc = c2_r; ncol = nc_r; end
    endcase
  end

  always_comb begin
    tag1_nxt.valid = busy_r;
    tag1_nxt.row   = nr;
    tag1_nxt.col   = ncol;
    tag1_nxt.last  = (k_r == K_LAST);
  end

  // det = c2*b1 - c1*b2, recomputed with every entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else if (adv) begin
      tag1_r <= tag1_nxt;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pb_r  <= prod_t'(br) * prod_t'(bc);
      pc_r  <= prod_t'(cr) * prod_t'(cc);
      pd1_r <= prod_t'(c2_r) * prod_t'(b1_r);
      pd2_r <= prod_t'(c1_r) * prod_t'(b2_r);
      num_r <= sum_t'(pb_r) + sum_t'(pc_r);
      det_r <= sum_t'(pd1_r) - sum_t'(pd2_r);
    end
  end

  always_comb begin
    frac_nxt.tag   = tag2_r;
    frac_nxt.neg   = num_r[SW-1];
    frac_nxt.degen = (det_r == '0);
    frac_nxt.mag   = num_r[SW-1] ? mag_t'(-num_r) : mag_t'(num_r);
    frac_nxt.den   = det_r[SW-1] ? mag_t'(-det_r) : mag_t'(det_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r.tag.valid <= 1'b0;
    end else if (adv) begin
      frac_r <= frac_nxt;
    end
  end

  assign frac = frac_r;

endmodule

// File: sv/p1tsa_div.sv
module p1tsa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  p1tsa_pkg::frac_t  frac,
  output p1tsa_pkg::res_t   res
);
  import p1tsa_pkg::*;

  typedef struct packed {
    tag_t            tag;
    logic            neg;
    logic            degen;
    logic            big;
    mag_t            den;
    logic [CW-1:0]   rem;
    logic [QB-1:0]   q;
  } stg_t;

  stg_t          st_r [QB+1];
  stg_t          st0_nxt;
  logic [CW-1:0] den_top;

  // quotient reaches 2^QB or more: saturates for sure
  assign den_top = CW'(frac.den) << (QB - FRAC_SHIFT);

  always_comb begin
    st0_nxt.tag   = frac.tag;
    st0_nxt.neg   = frac.neg;
    st0_nxt.degen = frac.degen;
    st0_nxt.big   = (CW'(frac.mag) >= den_top);
    st0_nxt.den   = frac.den;
    st0_nxt.rem   = CW'(frac.mag) << FRAC_SHIFT;
    st0_nxt.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].tag.valid <= 1'b0;
    end else if (adv) begin
      st_r[0] <= st0_nxt;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [CW-1:0] dsh;
    logic          ge;
    stg_t          nxt;

    assign dsh = CW'(st_r[i].den) << (QB - 1 - i);
    assign ge  = (st_r[i].rem >= dsh);

    always_comb begin
      nxt     = st_r[i];
      nxt.rem = ge ? (st_r[i].rem - dsh) : st_r[i].rem;
      nxt.q   = st_r[i].q | ({{(QB-1){1'b0}}, ge} << (QB - 1 - i));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i+1].tag.valid <= 1'b0;
      end else if (adv) begin
        st_r[i+1] <= nxt;
      end
    end
  end

  stg_t              fin;
  logic              up;
  logic [QB:0]       q1;
  localparam logic [QB:0] LIM = (QB+1)'(1) << (VALUE_BITS - 1);

  assign fin = st_r[QB];
  assign up  = ((fin.rem << 1) >= CW'(fin.den));   // round half up
  assign q1  = {1'b0, fin.q} + (QB+1)'(up);

  always_comb begin
    res.tag   = fin.tag;
    res.degen = fin.degen;
    res.sat   = 1'b0;
    res.value = '0;
    priority if (fin.degen) begin
      res.value = '0;
    end else if (fin.neg) begin
      if (fin.big || q1 > LIM) begin
        res.sat   = 1'b1;
        res.value = VAL_MIN;
      end else begin
        res.value = -q1[VALUE_BITS-1:0];
      end
    end else begin
      if (fin.big || q1 > LIM - 1'b1) begin
        res.sat   = 1'b1;
        res.value = VAL_MAX;
      end else begin
        res.value = q1[VALUE_BITS-1:0];
      end
    end
  end

endmodule

// File: sv/p1_triangle_stiffness_assembly.sv
// channel | direction | transfer contents
// in_     | input     | one triangle: node_a/b/c, ax, ay, bx, by_coord, cx, cy
// out_    | output    | one triplet: row_node, col_node, entry_value, flags
//
// The entry sequencer issues one matrix entry per cycle through its multiplier set
// unless an out_ stall holds it, and takes the next triangle with the last of nine entries.
// Each entry then passes the product, sum, fraction, divider and output registers.
// rst_n is synchronous, active low; it clears all valid bits and the sequencer.
// An out_ stall freezes every stage at once; nothing is dropped or repeated.
`include "p1_triangle_stiffness_assembly_assert.svh"

module p1_triangle_stiffness_assembly (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [p1tsa_pkg::NODE_INDEX_BITS-1:0]   in_node_a,
  input  logic [p1tsa_pkg::NODE_INDEX_BITS-1:0]   in_node_b,
  input  logic [p1tsa_pkg::NODE_INDEX_BITS-1:0]   in_node_c,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_ax,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_ay,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_bx,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_by_coord,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_cx,
  input  logic signed [p1tsa_pkg::COORD_BITS-1:0] in_cy,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [p1tsa_pkg::NODE_INDEX_BITS-1:0]   out_row_node,
  output logic [p1tsa_pkg::NODE_INDEX_BITS-1:0]   out_col_node,
  output logic signed [p1tsa_pkg::VALUE_BITS-1:0] out_entry_value,
  output logic                                    out_degenerate,
  output logic                                    out_saturated,
  output logic                                    out_last
);
  import p1tsa_pkg::*;

  logic  adv;
  frac_t frac;
  res_t  res;

  logic   out_valid_r;
  node_t  out_row_node_r, out_col_node_r;
  value_t out_entry_value_r;
  logic   out_degenerate_r, out_saturated_r, out_last_r;

  // whole pipeline moves whenever the output register can take a word
  assign adv = !out_valid_r || out_ready;

  // triangle capture, entry walk, products, sums, magnitudes
  p1tsa_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_node_a   (in_node_a),
    .in_node_b   (in_node_b),
    .in_node_c   (in_node_c),
    .in_ax       (in_ax),
    .in_ay       (in_ay),
    .in_bx       (in_bx),
    .in_by_coord (in_by_coord),
    .in_cx       (in_cx),
    .in_cy       (in_cy),
    .frac        (frac)
  );

  // pipelined divide by |det|, rounding, clipping
  p1tsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .frac  (frac),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row_node_r    <= res.tag.row;
      out_col_node_r    <= res.tag.col;
      out_entry_value_r <= res.value;
      out_degenerate_r  <= res.degen;
      out_saturated_r   <= res.sat;
      out_last_r        <= res.tag.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_node    = out_row_node_r;
  assign out_col_node    = out_col_node_r;
  assign out_entry_value = out_entry_value_r;
  assign out_degenerate  = out_degenerate_r;
  assign out_saturated   = out_saturated_r;
  assign out_last        = out_last_r;

  `P1TSA_ASSERT_IMP(a_degen_zero, out_valid_r && out_degenerate_r, out_entry_value_r == '0 && !out_saturated_r)
  `P1TSA_ASSERT_IMP(a_sat_extreme, out_valid_r && out_saturated_r, out_entry_value_r == VAL_MAX || out_entry_value_r == VAL_MIN)
  `P1TSA_ASSERT_IMP(a_ready_moves, in_ready, !out_valid_r || out_ready)
  `P1TSA_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule
